// File: src/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF task table package
// Entry layout, action codes and status codes shared by the task table files.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int ID_W    = 32;
    localparam int OWNER_W = 3;
    localparam int DL_W    = 32;
    localparam int TOTAL_W = 16;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
        logic [DL_W-1:0]    dl;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic ACT_RELEASE  = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

endpackage

// File: src/edf_ram.sv
// ----------------------------------------------------------------------------
// EDF generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
    parameter int WIDTH = 67,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/edf_deadline_task_table_core.sv
// ----------------------------------------------------------------------------
// EDF deadline task table core
// Keeps active tasks sorted by deadline in one RAM and reports the head task
// and the on-time and late completion totals after every command.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  command   start, busy         i_action, i_task_id, i_task_owner,
//                                i_deadline, i_now
//  result    o_done (strobe)     o_status, o_was_late, o_head_valid,
//                                o_head_task_id, o_head_owner,
//                                o_head_deadline, o_live_tasks,
//                                o_on_time_total, o_late_total
//
// o_done rises after any table walk, the head read in S_HRD and the output
// register in S_HOUT; busy is high until then. The single RAM read port paces
// the walk: an insert walks the table from the tail, a completion walks it from
// the head, one entry per cycle, and a final read of entry 0 fetches the head.
// Reset is synchronous and empties the table; the RAM itself is not cleared.
// The result receiver cannot stall; busy stays high until o_done is issued.
// ----------------------------------------------------------------------------
module edf_deadline_task_table_core
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    localparam int AW = $clog2(MAX_TASKS),
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [OWNER_W-1:0] i_task_owner,
    input  logic [DL_W-1:0]    i_deadline,
    input  logic [DL_W-1:0]    i_now,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic               o_was_late,
    output logic               o_head_valid,
    output logic [ID_W-1:0]    o_head_task_id,
    output logic [OWNER_W-1:0] o_head_owner,
    output logic [DL_W-1:0]    o_head_deadline,
    output logic [CW-1:0]      o_live_tasks,
    output logic [TOTAL_W-1:0] o_on_time_total,
    output logic [TOTAL_W-1:0] o_late_total
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_WNEW = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_HRD  = 3'd4;
    localparam logic [2:0] S_HOUT = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [TOTAL_W-1:0] r_on_time, n_on_time;
    logic [TOTAL_W-1:0] r_late_total, n_late_total;
    logic               r_done, n_done;

    logic [CW-1:0]      r_k, n_k;
    logic [AW-1:0]      r_j, n_j;
    logic               r_found, n_found;
    logic               r_late, n_late;
    t_status            r_status, n_status;
    t_entry             r_new, n_new;
    logic [DL_W-1:0]    r_now, n_now;

    t_status            r_out_status;
    logic               r_out_late;
    logic               r_out_head_valid;
    t_entry             r_out_head;
    logic [CW-1:0]      r_out_count;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    t_entry             w_wr_data;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    t_entry             w_rd_data;
    logic [ENTRY_W-1:0] w_rd_bits;
    logic               w_accept;
    logic               w_match;
    logic               w_last;

    edf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_bits)
    );

    assign w_rd_data = t_entry'(w_rd_bits);
    assign w_accept  = start && (r_state == S_IDLE);
    assign w_match   = !r_found && (w_rd_data.id == r_new.id);
    assign w_last    = (CW'(r_j) == (r_count - CW'(1)));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_on_time    = r_on_time;
        n_late_total = r_late_total;
        n_done       = 1'b0;
        n_k          = r_k;
        n_j          = r_j;
        n_found      = r_found;
        n_late       = r_late;
        n_status     = r_status;
        n_new        = r_new;
        n_now        = r_now;
        w_wr_en      = 1'b0;
        w_wr_addr    = '0;
        w_wr_data    = r_new;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new.id    = i_task_id;
                    n_new.owner = i_task_owner;
                    n_new.dl    = i_deadline;
                    n_now       = i_now;
                    n_status    = ST_OK;
                    n_late      = 1'b0;
                    n_found     = 1'b0;
                    if (i_action == ACT_RELEASE) begin
                        if (r_count == CW'(MAX_TASKS)) begin
                            n_status = ST_FULL;
                            n_state  = S_HRD;
                        end else if (r_count == '0) begin
                            n_state = S_WNEW;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = AW'(r_count - CW'(1));
                            n_k       = r_count;
                            n_state   = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_HRD;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_j       = '0;
                            n_state   = S_SCAN;
                        end
                    end
                end
            end
            S_INS: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_k);
                if (w_rd_data.dl > r_new.dl) begin
                    w_wr_data = w_rd_data;
                    if (r_k == CW'(1)) begin
                        n_state = S_WNEW;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = AW'(r_k - CW'(2));
                        n_k       = r_k - CW'(1);
                    end
                end else begin
                    w_wr_data = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_HRD;
                end
            end
            S_WNEW: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = r_new;
                n_count   = r_count + CW'(1);
                n_state   = S_HRD;
            end
            S_SCAN: begin
                if (r_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_j - AW'(1);
                    w_wr_data = w_rd_data;
                end
                if (w_match) begin
                    n_found = 1'b1;
                    n_late  = (r_now > w_rd_data.dl);
                end
                if (w_last) begin
                    n_state = S_HRD;
                    if (r_found || w_match) begin
                        n_count = r_count - CW'(1);
                        if (n_late) begin
                            if (r_late_total != '1) begin
                                n_late_total = r_late_total + TOTAL_W'(1);
                            end
                        end else begin
                            if (r_on_time != '1) begin
                                n_on_time = r_on_time + TOTAL_W'(1);
                            end
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_j + AW'(1);
                    n_j       = r_j + AW'(1);
                end
            end
            S_HRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_state   = S_HOUT;
            end
            S_HOUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_on_time    <= '0;
            r_late_total <= '0;
            r_done       <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_on_time    <= n_on_time;
            r_late_total <= n_late_total;
            r_done       <= n_done;
            r_found      <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_j      <= n_j;
        r_late   <= n_late;
        r_status <= n_status;
        r_new    <= n_new;
        r_now    <= n_now;
        if (r_state == S_HOUT) begin
            r_out_status     <= r_status;
            r_out_late       <= r_late && (r_status == ST_OK);
            r_out_head_valid <= (r_count != '0);
            r_out_head       <= (r_count != '0) ? w_rd_data : '0;
            r_out_count      <= r_count;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_out_status;
    assign o_was_late      = r_out_late;
    assign o_head_valid    = r_out_head_valid;
    assign o_head_task_id  = r_out_head.id;
    assign o_head_owner    = r_out_head.owner;
    assign o_head_deadline = r_out_head.dl;
    assign o_live_tasks    = r_out_count;
    assign o_on_time_total = r_on_time;
    assign o_late_total    = r_late_total;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("active task count exceeds the table depth");

    a_done_after_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_state == S_HOUT))
        else $error("result strobe without a head fetch");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_HRD || r_state == S_HOUT) |-> !w_wr_en)
        else $error("table written outside an update walk");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_live_tasks == CW'(MAX_TASKS)))
        else $error("full status reported on a table that is not full");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_live_tasks == '0)) |-> !o_head_valid)
        else $error("head reported on an empty table");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDF deadline task table testbench
// Sends release and complete commands through the start/busy handshake and
// predicts every result with a local deadline-sorted task table. Each result
// is compared field by field with the oldest prediction. The stimulus covers
// directed corner cases and random fill and drain traffic with duplicate ids
// and tied deadlines.
// ----------------------------------------------------------------------------
module tb_top
    import edf_pkg::*;
();

    localparam int MAX_TASKS  = 16;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int QUIET_MAX  = 1000;
    localparam int SETTLE     = 2 * MAX_TASKS + 8;
    localparam int RAND_ITEMS = 200;
    localparam int BACKLOG    = 64;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
        logic [DL_W-1:0]    deadline;
        logic [DL_W-1:0]    now;
        logic [7:0]         gap_after;
        logic               hold_for_drain;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic               was_late;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [OWNER_W-1:0] head_owner;
        logic [DL_W-1:0]    head_dl;
        logic [CNT_W-1:0]   active;
        logic [TOTAL_W-1:0] completed;
        logic [TOTAL_W-1:0] overdue;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               i_action = ACT_RELEASE;
    logic [ID_W-1:0]    i_task_id = '0;
    logic [OWNER_W-1:0] i_task_owner = '0;
    logic [DL_W-1:0]    i_deadline = '0;
    logic [DL_W-1:0]    i_now = '0;
    logic               busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic               o_was_late;
    logic               o_head_valid;
    logic [ID_W-1:0]    o_head_task_id;
    logic [OWNER_W-1:0] o_head_owner;
    logic [DL_W-1:0]    o_head_deadline;
    logic [CNT_W-1:0]   o_live_tasks;
    logic [TOTAL_W-1:0] o_on_time_total;
    logic [TOTAL_W-1:0] o_late_total;

    t_cmd     cmd_backlog[$];
    t_outcome expected_outcomes[$];

    logic [ID_W-1:0]    task_ids[MAX_TASKS];
    logic [DL_W-1:0]    task_dls[MAX_TASKS];
    logic [OWNER_W-1:0] task_owners[MAX_TASKS];
    int                 live_count = 0;
    logic [TOTAL_W-1:0] on_time_total = '0;
    logic [TOTAL_W-1:0] late_total = '0;

    logic [ID_W-1:0] plan_ids[$];
    logic [DL_W-1:0] plan_dls[$];
    bit              filling = 1'b1;
    int              calm_left = 0;

    int   cmds_queued = 0;
    int   cmds_taken = 0;
    int   mismatches = 0;
    int   gap_left = 0;
    int   quiet_cycles = 0;
    logic took_cmd = 1'b0;

    edf_deadline_task_table_core #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_task_id(i_task_id),
        .i_task_owner(i_task_owner),
        .i_deadline(i_deadline),
        .i_now(i_now),
        .o_done(o_done),
        .o_status(o_status),
        .o_was_late(o_was_late),
        .o_head_valid(o_head_valid),
        .o_head_task_id(o_head_task_id),
        .o_head_owner(o_head_owner),
        .o_head_deadline(o_head_deadline),
        .o_live_tasks(o_live_tasks),
        .o_on_time_total(o_on_time_total),
        .o_late_total(o_late_total)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic update_schedule(input t_cmd c, output t_outcome r);
        int pos;
        r = '0;
        r.status = ST_OK;
        if (c.action == ACT_RELEASE) begin
            if (live_count >= MAX_TASKS) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < live_count && task_dls[pos] <= c.deadline) pos++;
                for (int k = live_count; k > pos; k--) begin
                    task_ids[k]    = task_ids[k-1];
                    task_dls[k]    = task_dls[k-1];
                    task_owners[k] = task_owners[k-1];
                end
                task_ids[pos]    = c.id;
                task_dls[pos]    = c.deadline;
                task_owners[pos] = c.owner;
                live_count++;
            end
        end else begin
            pos = 0;
            while (pos < live_count && task_ids[pos] != c.id) pos++;
            if (pos == live_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                if (c.now <= task_dls[pos]) begin
                    if (on_time_total != '1) on_time_total++;
                end else begin
                    r.was_late = 1'b1;
                    if (late_total != '1) late_total++;
                end
                for (int k = pos; k + 1 < live_count; k++) begin
                    task_ids[k]    = task_ids[k+1];
                    task_dls[k]    = task_dls[k+1];
                    task_owners[k] = task_owners[k+1];
                end
                live_count--;
            end
        end
        if (live_count > 0) begin
            r.head_valid = 1'b1;
            r.head_id    = task_ids[0];
            r.head_owner = task_owners[0];
            r.head_dl    = task_dls[0];
        end
        r.active    = CNT_W'(live_count);
        r.completed = on_time_total;
        r.overdue   = late_total;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Results are checked before the new transfer is predicted, so a result
    // and a transfer at the same edge stay in order.
    always @(posedge i_clk) begin
        t_outcome want;
        t_cmd     c;
        bit       took;
        took = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result strobe with no command outstanding");
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("was_late", 32'(want.was_late), 32'(o_was_late));
                    check_field("head_valid", 32'(want.head_valid), 32'(o_head_valid));
                    check_field("head_task_id", want.head_id, o_head_task_id);
                    check_field("head_owner", 32'(want.head_owner), 32'(o_head_owner));
                    check_field("head_deadline", want.head_dl, o_head_deadline);
                    check_field("live_tasks", 32'(want.active), 32'(o_live_tasks));
                    check_field("on_time_total", 32'(want.completed),
                                32'(o_on_time_total));
                    check_field("late_total", 32'(want.overdue), 32'(o_late_total));
                end
            end
            if (start && !busy) begin
                c = '0;
                c.action   = i_action;
                c.id       = i_task_id;
                c.owner    = i_task_owner;
                c.deadline = i_deadline;
                c.now      = i_now;
                update_schedule(c, want);
                expected_outcomes.push_back(want);
                cmds_taken++;
                took = 1'b1;
            end
        end
        took_cmd <= took;
    end

    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && (!start || took_cmd)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].hold_for_drain && expected_outcomes.size() > 0)) begin
                c = cmd_backlog.pop_front();
                i_action     <= c.action;
                i_task_id    <= c.id;
                i_task_owner <= c.owner;
                i_deadline   <= c.deadline;
                i_now        <= c.now;
                gap_left     <= int'(c.gap_after);
                start        <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 8'd0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(10, 40);
            return 8'd0;
        end
        if (roll < 55) return 8'd0;
        if (roll < 90) return 8'($urandom_range(1, 3));
        return 8'($urandom_range(8, 40));
    endfunction

    task automatic queue_cmd(input logic act, input logic [ID_W-1:0] id,
                             input logic [OWNER_W-1:0] owner, input logic [DL_W-1:0] dl,
                             input logic [DL_W-1:0] now, input logic [7:0] gap,
                             input logic drain);
        t_cmd c;
        int   idx;
        while (cmd_backlog.size() >= BACKLOG) @(posedge i_clk);
        c.action         = act;
        c.id             = id;
        c.owner          = owner;
        c.deadline       = dl;
        c.now            = now;
        c.gap_after      = gap;
        c.hold_for_drain = drain;
        cmd_backlog.push_back(c);
        cmds_queued++;
        if (act == ACT_RELEASE) begin
            if (plan_ids.size() < MAX_TASKS) begin
                plan_ids.push_back(id);
                plan_dls.push_back(dl);
            end
        end else begin
            idx = -1;
            foreach (plan_ids[k]) if (idx < 0 && plan_ids[k] == id) idx = k;
            if (idx >= 0) begin
                plan_ids.delete(idx);
                plan_dls.delete(idx);
            end
        end
    endtask

    // Traffic alternates between filling and draining the table so that both
    // the full and the empty table are reached again and again.
    task automatic queue_random_cmd();
        int              roll;
        int              idx;
        logic            act;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
        logic [DL_W-1:0] now;
        if (plan_ids.size() == 0) filling = 1'b1;
        else if (plan_ids.size() == MAX_TASKS && $urandom_range(0, 2) == 0) filling = 1'b0;
        else if ($urandom_range(0, 49) == 0) filling = !filling;
        act = (($urandom_range(0, 3) != 0) == filling) ? ACT_RELEASE : ACT_COMPLETE;
        id  = $urandom;
        dl  = $urandom;
        now = $urandom;
        roll = $urandom_range(0, 99);
        if (act == ACT_RELEASE) begin
            if (roll < 15 && plan_ids.size() > 0)
                id = plan_ids[$urandom_range(0, plan_ids.size() - 1)];
            else if (roll < 40)
                id = $urandom_range(0, 7);
            roll = $urandom_range(0, 99);
            if (roll < 35) dl = $urandom_range(0, 15);
            else if (roll < 40) dl = '0;
            else if (roll < 45) dl = '1;
        end else if (roll < 80 && plan_ids.size() > 0) begin
            idx = $urandom_range(0, plan_ids.size() - 1);
            id  = plan_ids[idx];
            case ($urandom_range(0, 3))
                0: now = plan_dls[idx];
                1: now = plan_dls[idx] + 1;
                2: now = plan_dls[idx] - 1;
                default: ;
            endcase
        end else if (roll < 90) begin
            id = $urandom_range(0, 7);
        end
        queue_cmd(act, id, 3'($urandom_range(0, 7)), dl, now, pick_gap(),
                  $urandom_range(0, 49) == 0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(ACT_COMPLETE, '0, '0, '0, '0, pick_gap(), 1'b0);
        queue_cmd(ACT_RELEASE, '1, '1, '1, $urandom, pick_gap(), 1'b0);
        queue_cmd(ACT_RELEASE, '0, '0, '0, $urandom, pick_gap(), 1'b0);
        queue_cmd(ACT_RELEASE, 32'd5, 3'd3, 32'd100, $urandom, pick_gap(), 1'b0);
        queue_cmd(ACT_RELEASE, 32'd5, 3'd4, 32'd100, $urandom, pick_gap(), 1'b0);
        queue_cmd(ACT_COMPLETE, 32'd12345, '0, $urandom, $urandom, pick_gap(), 1'b0);
        queue_cmd(ACT_COMPLETE, 32'd5, '0, $urandom, 32'd100, pick_gap(), 1'b0);
        queue_cmd(ACT_COMPLETE, 32'd5, '0, $urandom, 32'd101, pick_gap(), 1'b0);
        queue_cmd(ACT_COMPLETE, '1, '0, $urandom, '1, pick_gap(), 1'b0);
        queue_cmd(ACT_COMPLETE, '0, '0, $urandom, 32'd1, pick_gap(), 1'b0);
        for (int n = 0; n <= MAX_TASKS; n++) begin
            queue_cmd(ACT_RELEASE, 32'd100 + n, 3'(n), $urandom_range(0, 3), $urandom,
                      pick_gap(), n == 0);
        end

        for (int n = 0; n < RAND_ITEMS; n++) queue_random_cmd();

        // Empty the table before the second random phase.
        while (plan_ids.size() > 0)
            queue_cmd(ACT_COMPLETE, plan_ids[0], '0, $urandom, $urandom, 8'd0, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++) queue_random_cmd();

        while (cmds_taken != cmds_queued || expected_outcomes.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/edf_pkg.sv
src/edf_ram.sv
src/edf_deadline_task_table_core.sv
verif/tb_top.sv
